// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the SHA-256 hasher.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, ignored while reset is low.
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check that a condition on one edge implies another on the next edge.
`define ASSERT_NEXT(label, clk, rstn, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (prop)) else $error(msg);

`endif

// ===== hw/rtl/sha256_pkg.sv =====
// Types and constants of the SHA-256 byte stream hasher.
// Holds the sequencer state type, opcodes, initial hash values, round
// constants and the sigma functions. No dependencies.
package sha256_pkg;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_UPDATE,
        ST_PAD,
        ST_LEN,
        ST_EMIT
    } state_t;

    // Input opcodes (carried on s_tuser)
    localparam logic OP_APPEND   = 1'b0;
    localparam logic OP_FINALIZE = 1'b1;

    localparam logic [7:0] PAD_MARK      = 8'h80;
    localparam logic [5:0] LEN_POS       = 6'd56;
    localparam logic [5:0] LAST_BYTE_POS = 6'd63;
    localparam logic [5:0] LAST_ROUND    = 6'd63;
    localparam logic [2:0] LAST_WORD_IDX = 3'd7;
    localparam logic [63:0] BYTE_BITS    = 64'd8;

    localparam logic [31:0] HASH_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

// ===== hw/rtl/sha256_byte_stream_hasher_unit.sv =====
// SHA-256 byte stream hasher: top level with block shift register,
// one shared round unit and the sequencer. Depends on sha256_pkg and
// assert_macros.svh.
//
//  channel | dir | tdata                  | tuser           | tlast
//  s_      | in  | [7:0] data_byte        | [0] opcode      | -
//  m_      | out | [31:0] digest_word      | [2:0] word_index| last_word
//
// An append word is shifted into the block; the one that fills a block then
// runs 64 rounds of the single round unit, then the chaining update.
// A finalize word with n pending bytes shifts padding bytes in ST_PAD up to
// the length field or the block end, then the length bytes in ST_LEN, and
// compresses each filled block (two blocks when n >= 56); it then emits eight
// output words, one per accepted m_ handshake.
// s_tready is high only while idle; a stalled m_ side holds the digest word.
// Reset (aresetn low, synchronous) restores the initial hash values.
`include "assert_macros.svh"

module sha256_byte_stream_hasher_unit
    import sha256_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] digest_word
    output logic [2:0]  m_tuser,   // [2:0] word_index
    output logic        m_tlast
);

    state_t        state_reg, state_next;
    logic [511:0]  blk_reg, blk_next;
    logic [31:0]   hash_reg [8];
    logic [31:0]   hash_next [8];
    logic [31:0]   work_reg [8];
    logic [31:0]   work_next [8];
    logic [5:0]    byte_cnt_reg, byte_cnt_next;
    logic [5:0]    round_cnt_reg, round_cnt_next;
    logic [2:0]    word_idx_reg, word_idx_next;
    logic [63:0]   bitlen_reg, bitlen_next;
    logic          mark_sent_reg, mark_sent_next;
    logic          len_sent_reg, len_sent_next;

    logic          s_accept, m_accept;
    logic          shift_en, load_work, do_round, do_update;
    logic          pad_done;
    logic [7:0]    shift_byte;
    logic [31:0]   w0, w1, w9, w14, w_new;
    logic [31:0]   t1, t2, ch, maj;

    assign s_accept = s_tvalid && s_tready;
    assign m_accept = m_tvalid && m_tready;
    assign pad_done = mark_sent_reg && (byte_cnt_reg == LEN_POS);

    // Schedule taps: word j of the window sits at the top-down position j
    assign w0  = blk_reg[511:480];
    assign w1  = blk_reg[479:448];
    assign w9  = blk_reg[223:192];
    assign w14 = blk_reg[63:32];
    assign w_new = small_sigma1(w14) + w9 + small_sigma0(w1) + w0;

    // Shared round unit
    assign ch  = (work_reg[4] & work_reg[5]) ^ (~work_reg[4] & work_reg[6]);
    assign maj = (work_reg[0] & work_reg[1]) ^ (work_reg[0] & work_reg[2])
               ^ (work_reg[1] & work_reg[2]);
    assign t1  = work_reg[7] + big_sigma1(work_reg[4]) + ch + ROUND_K[round_cnt_reg] + w0;
    assign t2  = big_sigma0(work_reg[0]) + maj;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    if (s_tuser == OP_FINALIZE) begin
                        state_next = ST_PAD;
                    end else if (byte_cnt_reg == LAST_BYTE_POS) begin
                        state_next = ST_ROUND;
                    end
                end
            end
            ST_ROUND: begin
                if (round_cnt_reg == LAST_ROUND) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (len_sent_reg) begin
                    state_next = ST_EMIT;
                end else if (mark_sent_reg) begin
                    state_next = ST_PAD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_PAD: begin
                if (pad_done) begin
                    state_next = ST_LEN;
                end else if (byte_cnt_reg == LAST_BYTE_POS) begin
                    state_next = ST_ROUND;
                end
            end
            ST_LEN: begin
                if (byte_cnt_reg == LAST_BYTE_POS) begin
                    state_next = ST_ROUND;
                end
            end
            ST_EMIT: begin
                if (m_accept && (word_idx_reg == LAST_WORD_IDX)) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        shift_en   = 1'b0;
        do_round   = 1'b0;
        do_update  = 1'b0;
        shift_byte = s_tdata;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                shift_en = s_accept && (s_tuser == OP_APPEND);
            end
            ST_ROUND:  do_round = 1'b1;
            ST_UPDATE: do_update = 1'b1;
            ST_PAD: begin
                shift_en   = !pad_done;
                shift_byte = mark_sent_reg ? 8'h00 : PAD_MARK;
            end
            ST_LEN: begin
                shift_en   = 1'b1;
                shift_byte = bitlen_reg[63:56];
            end
            ST_EMIT:   m_tvalid = 1'b1;
            default: begin
                s_tready = 1'b0;
            end
        endcase
        load_work = (state_next == ST_ROUND) && (state_reg != ST_ROUND);
    end

    // Datapath next values
    always_comb begin
        blk_next       = blk_reg;
        byte_cnt_next  = byte_cnt_reg;
        round_cnt_next = round_cnt_reg;
        word_idx_next  = word_idx_reg;
        bitlen_next    = bitlen_reg;
        mark_sent_next = mark_sent_reg;
        len_sent_next  = len_sent_reg;
        hash_next      = hash_reg;
        work_next      = work_reg;

        // Shift one message, padding or length byte into the block
        if (shift_en) begin
            blk_next      = {blk_reg[503:0], shift_byte};
            byte_cnt_next = byte_cnt_reg + 6'd1;
        end
        if (state_reg == ST_IDLE && s_accept) begin
            if (s_tuser == OP_APPEND) begin
                bitlen_next = bitlen_reg + BYTE_BITS;
            end else begin
                mark_sent_next = 1'b0;
                len_sent_next  = 1'b0;
            end
        end
        if (state_reg == ST_PAD && !pad_done) begin
            mark_sent_next = 1'b1;
        end
        if (state_reg == ST_LEN) begin
            bitlen_next = {bitlen_reg[55:0], 8'h00};
            if (byte_cnt_reg == LAST_BYTE_POS) begin
                len_sent_next = 1'b1;
            end
        end

        // Start a block from the chaining words
        if (load_work) begin
            work_next      = hash_reg;
            round_cnt_next = '0;
        end

        // One compression round; slide the schedule window
        if (do_round) begin
            work_next[7]   = work_reg[6];
            work_next[6]   = work_reg[5];
            work_next[5]   = work_reg[4];
            work_next[4]   = work_reg[3] + t1;
            work_next[3]   = work_reg[2];
            work_next[2]   = work_reg[1];
            work_next[1]   = work_reg[0];
            work_next[0]   = t1 + t2;
            blk_next       = {blk_reg[479:0], w_new};
            round_cnt_next = round_cnt_reg + 6'd1;
        end

        // Fold the working words into the chaining words
        if (do_update) begin
            for (int i = 0; i < 8; i++) begin
                hash_next[i] = hash_reg[i] + work_reg[i];
            end
        end

        // Advance the digest word; restart the message after the last one
        if (m_accept) begin
            word_idx_next = word_idx_reg + 3'd1;
            if (word_idx_reg == LAST_WORD_IDX) begin
                hash_next      = HASH_IV;
                byte_cnt_next  = '0;
                bitlen_next    = '0;
                mark_sent_next = 1'b0;
                len_sent_next  = 1'b0;
            end
        end
    end

    // Control and chaining state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            hash_reg      <= HASH_IV;
            byte_cnt_reg  <= '0;
            round_cnt_reg <= '0;
            word_idx_reg  <= '0;
            bitlen_reg    <= '0;
            mark_sent_reg <= 1'b0;
            len_sent_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            hash_reg      <= hash_next;
            byte_cnt_reg  <= byte_cnt_next;
            round_cnt_reg <= round_cnt_next;
            word_idx_reg  <= word_idx_next;
            bitlen_reg    <= bitlen_next;
            mark_sent_reg <= mark_sent_next;
            len_sent_reg  <= len_sent_next;
        end
    end

    // Block window and working words
    always_ff @(posedge aclk) begin
        blk_reg  <= blk_next;
        work_reg <= work_next;
    end

    // Result channel
    assign m_tdata = hash_reg[word_idx_reg];
    assign m_tuser = word_idx_reg;
    assign m_tlast = (word_idx_reg == LAST_WORD_IDX);

    // Checks
    `ASSERT_CLK(a_no_overlap, aclk, aresetn, !(s_tready && m_tvalid), "input and output both open")
    `ASSERT_CLK(a_emit_block_empty, aclk, aresetn, !m_tvalid || (byte_cnt_reg == '0), "bytes pending")
    `ASSERT_CLK(a_round_cnt_idle, aclk, aresetn, (state_reg == ST_ROUND) || (round_cnt_reg == '0), "round count")
    `ASSERT_NEXT(a_restart, aclk, aresetn, m_accept && m_tlast, s_tready && (bitlen_reg == '0), "no restart")

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for sha256_byte_stream_hasher_unit: streams messages
// byte by byte, predicts every digest word with its own SHA-256 model and checks it.
// Depends on sha256_pkg (opcodes) and the hasher RTL.
`timescale 1ns / 1ps

module tb_top;
    import sha256_pkg::OP_APPEND;
    import sha256_pkg::OP_FINALIZE;

    localparam int CLK_HALF      = 2;
    localparam int RESET_CYCLES  = 8;
    localparam int MSG_TARGET    = 250;
    localparam int MIN_DIGESTS   = 8;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 200;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int MAX_REPORTS   = 10;
    localparam int LEN_FIELD_POS = 56;
    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [63:0] BLOCK_BIT_COUNT = 64'd512;

    localparam logic [31:0] IV_TAB [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] K_TAB [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef struct packed {
        logic       op;
        logic [7:0] data;
    } hash_req_t;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } digest_exp_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;   // [7:0] data_byte
    logic        s_tuser  = 1'b0;    // [0] opcode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;            // [31:0] digest_word
    logic [2:0]  m_tuser;            // [2:0] word_index
    logic        m_tlast;

    hash_req_t   req_q[$];
    digest_exp_t digest_q[$];

    // predictor state
    logic [31:0] hv [8];
    logic [7:0]  blk [64];
    logic [5:0]  fill;
    logic [63:0] bit_len;

    int unsigned cycle_count   = 0;
    int unsigned err_count     = 0;
    int unsigned words_checked = 0;
    int unsigned digests_done  = 0;
    int unsigned bytes_hashed  = 0;
    int unsigned extra_blocks  = 0;
    int unsigned longest_msg   = 0;
    int unsigned cur_msg_len   = 0;
    int unsigned gap_left      = 0;
    int unsigned burst_left    = 0;
    int unsigned hold_left     = 0;
    int unsigned phase_cnt     = 0;
    int unsigned stall_mode    = 0;
    logic        held_once     = 1'b0;

    sha256_byte_stream_hasher_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #CLK_HALF aclk = ~aclk;

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        logic [63:0] dbl;
        dbl = {x, x} >> n;
        return dbl[31:0];
    endfunction

    // Fold the current 64-byte block into the chaining words.
    function automatic void fold_block();
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
        int i;
        for (i = 0; i < 16; i++) begin
            w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
        end
        for (i = 16; i < 64; i++) begin
            s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = s1 + w[i-7] + s0 + w[i-16];
        end
        {a, b, c, d, e, f, g, h} = {hv[0], hv[1], hv[2], hv[3], hv[4], hv[5], hv[6], hv[7]};
        for (i = 0; i < 64; i++) begin
            t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
                 + K_TAB[i] + w[i];
            t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        hv[0] += a; hv[1] += b; hv[2] += c; hv[3] += d;
        hv[4] += e; hv[5] += f; hv[6] += g; hv[7] += h;
    endfunction

    function automatic void clear_hash_state();
        for (int i = 0; i < 64; i++) blk[i] = 8'h00;
        for (int i = 0; i < 8; i++) hv[i] = IV_TAB[i];
        fill    = '0;
        bit_len = '0;
    endfunction

    // Absorb one accepted word; a finalize queues the eight digest words.
    function automatic void absorb_word(input logic op, input logic [7:0] data);
        int n;
        logic [63:0] total;
        if (op == OP_APPEND) begin
            blk[fill] = data;
            fill = fill + 1'b1;
            if (fill == 0) begin
                bit_len += BLOCK_BIT_COUNT;
                fold_block();
            end
            return;
        end
        n = fill;
        blk[n] = PAD_BYTE;
        for (int i = n + 1; i < 64; i++) blk[i] = 8'h00;
        // no room for the length field: spill into one more block
        if (n >= LEN_FIELD_POS) begin
            fold_block();
            for (int i = 0; i < LEN_FIELD_POS; i++) blk[i] = 8'h00;
            extra_blocks++;
        end
        total = bit_len + 64'(n) * 64'd8;
        for (int i = 0; i < 8; i++) blk[LEN_FIELD_POS + i] = total[63 - 8*i -: 8];
        fold_block();
        for (int i = 0; i < 8; i++) begin
            digest_q.push_back('{word: hv[i], idx: 3'(i), last: (i == 7)});
        end
        clear_hash_state();
    endfunction

    task automatic push_req(input logic op, input logic [7:0] data);
        req_q.push_back('{op: op, data: data});
    endtask

    // Drive s_ side: bursts of random length separated by random gaps.
    always @(posedge aclk) begin : drive_s
        hash_req_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end else if (req_q.size() != 0) begin
                nxt = req_q.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= nxt.op;
                s_tdata  <= nxt.data;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Drive m_tready: a stall pattern that phase_cnt periodically re-draws from four modes, plus one long hold-off.
    always @(posedge aclk) begin : drive_m
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (!held_once && m_tvalid && digests_done >= 2) begin
            held_once <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else begin
            case (stall_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                2: m_tready <= (phase_cnt % 3 == 0);
                default: m_tready <= ($urandom_range(0, 7) == 0);
            endcase
        end
        phase_cnt <= phase_cnt + 1;
        if (phase_cnt % 64 == 63) begin
            stall_mode <= $urandom_range(0, 3);
        end
    end

    // Monitor: predict on accepted input words, check accepted digest words.
    always @(posedge aclk) begin : monitor
        digest_exp_t exp_w;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                absorb_word(s_tuser, s_tdata);
                if (s_tuser == OP_APPEND) begin
                    bytes_hashed++;
                    cur_msg_len++;
                end else begin
                    if (cur_msg_len > longest_msg) longest_msg = cur_msg_len;
                    cur_msg_len = 0;
                end
            end
            if (m_tvalid && m_tready) begin
                if (digest_q.size() == 0) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS) begin
                        $display("ERROR: unexpected digest word %h idx %0d last %b",
                                 m_tdata, m_tuser, m_tlast);
                    end
                end else begin
                    exp_w = digest_q.pop_front();
                    words_checked++;
                    if (exp_w.last) digests_done++;
                    if (m_tdata !== exp_w.word || m_tuser !== exp_w.idx
                            || m_tlast !== exp_w.last) begin
                        err_count++;
                        if (err_count <= MAX_REPORTS) begin
                            $display("ERROR: digest word mismatch: exp %h/%0d/%b got %h/%0d/%b",
                                     exp_w.word, exp_w.idx, exp_w.last,
                                     m_tdata, m_tuser, m_tlast);
                        end
                    end
                end
            end
        end
    end

    // Watchdog on total run length.
    always @(posedge aclk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("ERROR: timeout after %0d cycles", cycle_count);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Build the stimulus, release reset, then wait for the last digest.
    initial begin : stimulus
        int unsigned items;
        int unsigned finals;
        int unsigned len;
        int unsigned fill_mode;
        logic [7:0] b;

        clear_hash_state();

        // empty messages, byte extremes, a short text message, an alternating-bit pair
        push_req(OP_FINALIZE, 8'h00);
        push_req(OP_APPEND, 8'h00);
        push_req(OP_APPEND, 8'hff);
        push_req(OP_FINALIZE, 8'hff);
        push_req(OP_APPEND, "a");
        push_req(OP_APPEND, "b");
        push_req(OP_APPEND, "c");
        push_req(OP_FINALIZE, 8'h5a);
        push_req(OP_APPEND, 8'h55);
        push_req(OP_APPEND, 8'haa);
        push_req(OP_FINALIZE, 8'ha5);
        push_req(OP_FINALIZE, 8'h00);
        items  = 12;
        finals = 5;

        // random messages, biased to lengths around the padding boundaries
        while (items < MSG_TARGET || finals < MIN_DIGESTS) begin
            case ($urandom_range(0, 4))
                0: len = $urandom_range(0, 10);
                1: len = $urandom_range(54, 57);
                2: len = $urandom_range(62, 65);
                3: len = $urandom_range(118, 121);
                default: len = $urandom_range(0, 130);
            endcase
            // trim the last message so the total stays near the target
            if (items + len + 1 > MSG_TARGET) begin
                len = (items + 1 < MSG_TARGET) ? MSG_TARGET - items - 1 : 0;
            end
            fill_mode = $urandom_range(0, 7);
            for (int i = 0; i < len; i++) begin
                case (fill_mode)
                    0: b = 8'h00;
                    1: b = 8'hff;
                    default: b = 8'($urandom_range(0, 255));
                endcase
                push_req(OP_APPEND, b);
            end
            push_req(OP_FINALIZE, 8'($urandom_range(0, 255)));
            items  += len + 1;
            finals += 1;
        end

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        while (req_q.size() != 0 || s_tvalid || digest_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (digest_q.size() != 0) begin
            err_count++;
            $display("ERROR: %0d digest words never arrived", digest_q.size());
        end
        $display("Hashed %0d messages, %0d bytes (longest %0d), %0d needing an extra block.",
                 digests_done, bytes_hashed, longest_msg, extra_blocks);
        $display("Checked %0d digest words under random stalls and one %0d-cycle hold-off.",
                 words_checked, HOLD_CYCLES);
        if (err_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("%0d mismatches in total", err_count);
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
